/* hdl/slg_pkg.sv */
// Shared types and constants for the speed limit governor.
`timescale 1ns / 1ps
`default_nettype none
package slg_pkg;

   // Serial arithmetic unit operations
   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } slg_op_type;

   typedef struct packed {
      logic       start;
      slg_op_type op;
   } slg_cmd_type;

   localparam int OPA_W = 36;
   localparam int OPB_W = 21;

   // Register indexes
   localparam logic [2:0] REG_DESIRED     = 3'd0;
   localparam logic [2:0] REG_MAX_ACCEL   = 3'd1;
   localparam logic [2:0] REG_GOAL_RADIUS = 3'd2;
   localparam logic [2:0] REG_TURN_THR    = 3'd3;
   localparam logic [2:0] REG_TURN_MIN    = 3'd4;
   localparam logic [2:0] REG_CLR_RADIUS  = 3'd5;
   localparam logic [2:0] REG_CLR_MIN     = 3'd6;
   localparam logic [2:0] REG_MAX_STEP    = 3'd7;

   // Reason codes
   localparam logic [3:0] RSN_HOLD      = 4'd0;
   localparam logic [3:0] RSN_INVALID   = 4'd1;
   localparam logic [3:0] RSN_CRUISE    = 4'd2;
   localparam logic [3:0] RSN_ACCEL     = 4'd3;
   localparam logic [3:0] RSN_GOAL      = 4'd4;
   localparam logic [3:0] RSN_TURN      = 4'd5;
   localparam logic [3:0] RSN_CLEARANCE = 4'd6;
   localparam logic [3:0] RSN_STEPCAP   = 4'd7;
   localparam logic [3:0] RSN_OVERSPEED = 4'd8;

   localparam logic [19:0] US_PER_S     = 20'd1000000;
   localparam logic [15:0] HALF_PI      = 16'd16384;

endpackage
`default_nettype wire

/* hdl/slg_serial.sv */
// Bit-serial multiply, divide and square root unit.
`timescale 1ns / 1ps
`default_nettype none
module slg_serial (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire slg_pkg::slg_cmd_type       cmd,
   input  wire logic [slg_pkg::OPA_W-1:0]  opa,
   input  wire logic [slg_pkg::OPB_W-1:0]  opb,
   output logic                            done,
   output logic [slg_pkg::OPA_W-1:0]       result
);
   import slg_pkg::*;

   slg_op_type        op_ff;
   logic              busy_ff, done_ff;
   logic [5:0]        cnt_ff;
   logic [35:0]       sh_ff, sh_in;
   logic [35:0]       acc_ff, acc_in;
   logic [15:0]       root_ff, root_in;
   logic [20:0]       div_ff;

   logic [21:0]       div_rs;
   logic              div_ge;
   logic [18:0]       sq_rs, sq_trial;
   logic [35:0]       mul_sum;

   always_comb begin
      div_rs   = {acc_ff[20:0], sh_ff[35]};
      div_ge   = div_rs >= {1'b0, div_ff};
      sq_rs    = {acc_ff[16:0], sh_ff[35:34]};
      sq_trial = {1'b0, root_ff, 2'b01};
      mul_sum  = {acc_ff[34:0], 1'b0} + (sh_ff[15] ? {16'd0, div_ff[19:0]} : 36'd0);
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      root_in  = root_ff;
      case (op_ff)
         OP_MUL: begin
            acc_in = mul_sum;
            sh_in  = {sh_ff[34:0], 1'b0};
         end
         OP_DIV: begin
            acc_in = div_ge ? {15'd0, 21'(div_rs - {1'b0, div_ff})} : {14'd0, div_rs};
            sh_in  = {sh_ff[34:0], div_ge};
         end
         OP_SQRT: begin
            if (sq_rs >= sq_trial) begin
               acc_in  = {17'd0, sq_rs - sq_trial};
               root_in = {root_ff[14:0], 1'b1};
            end else begin
               acc_in  = {17'd0, sq_rs};
               root_in = {root_ff[14:0], 1'b0};
            end
            sh_in = {sh_ff[33:0], 2'b00};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
         op_ff   <= OP_MUL;
      end else begin
         done_ff <= busy_ff && !cmd.start && (cnt_ff == 6'd1);
         if (cmd.start) begin
            op_ff   <= cmd.op;
            busy_ff <= 1'b1;
            acc_ff  <= 36'd0;
            root_ff <= 16'd0;
            div_ff  <= opb;
            case (cmd.op)
               OP_MUL: begin
                  sh_ff  <= {20'd0, opa[15:0]};
                  cnt_ff <= 6'd16;
               end
               OP_DIV: begin
                  sh_ff  <= opa;
                  cnt_ff <= 6'd36;
               end
               OP_SQRT: begin
                  sh_ff  <= {opa[31:0], 4'd0};
                  cnt_ff <= 6'd16;
               end
               default: begin
                  sh_ff  <= opa;
                  cnt_ff <= 6'd1;
               end
            endcase
         end else if (busy_ff) begin
            sh_ff   <= sh_in;
            acc_ff  <= acc_in;
            root_ff <= root_in;
            cnt_ff  <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1)
               busy_ff <= 1'b0;
         end
      end
   end

   assign done = done_ff;

   always_comb begin
      case (op_ff)
         OP_MUL:  result = acc_ff;
         OP_DIV:  result = sh_ff;
         OP_SQRT: result = {20'd0, root_ff};
         default: result = acc_ff;
      endcase
   end

endmodule
`default_nettype wire

/* hdl/speed_limit_governor.sv */
// Speed limit governor top level: sequencer, limit logic and register file.
//
//  channel | ports            | direction | transfer when
//  --------+------------------+-----------+------------------------------
//  request | req_valid/ready  | in        | req_valid && req_ready
//  result  | rsp_valid/ready  | out       | rsp_valid && rsp_ready
//  config  | csr_we/addr/data | in        | csr_we (no wait, no read-back)
//
// One tick at a time. All products, quotients and the goal-limit root run on one
// shared bit-serial unit. The time from one request transfer to the next depends
// on how many of the goal, turn and clearance ramps are needed and whether the
// goal-limit root saturates. Hold and invalid ticks skip the unit and go straight
// to the result register. Reset is synchronous and clears the registers to their
// defaults and the kept speed to zero.
// The result register frees the datapath: a new request is taken while the
// previous result still waits; a stalled result stalls only the next finish.
`timescale 1ns / 1ps
`default_nettype none
module speed_limit_governor #(
   parameter int BRAKE_MARGIN_MM = 0,
   parameter int MIN_CMD_SPEED   = 0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_hold,
   input  wire logic [19:0] req_goal_distance,
   input  wire logic signed [15:0] req_turn_angle,
   input  wire logic [19:0] req_clearance,
   input  wire logic        req_clearance_known,
   input  wire logic [19:0] req_time_step,
   input  wire logic [15:0] req_measured_speed,
   input  wire logic        req_measured_known,
   // result
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_requested_speed,
   output logic [15:0]      rsp_allowed_speed,
   output logic [15:0]      rsp_target_step,
   output logic [19:0]      rsp_braking_distance,
   output logic [15:0]      rsp_goal_limit,
   output logic [15:0]      rsp_turn_limit,
   output logic [15:0]      rsp_clearance_limit,
   output logic [15:0]      rsp_step_cap_limit,
   output logic [3:0]       rsp_limit_reason,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [19:0] csr_wdata
);
   import slg_pkg::*;

   localparam logic [19:0] MARGIN  = 20'(BRAKE_MARGIN_MM);
   localparam logic [15:0] MIN_SPD = 16'(MIN_CMD_SPEED);

   typedef enum logic [4:0] {
      ST_IDLE, ST_G_MUL, ST_G_SQRT, ST_R_MUL, ST_R_DIV, ST_T_MUL, ST_T_DIV,
      ST_C_MUL, ST_C_DIV, ST_S_MUL, ST_S_DIV, ST_D_MUL, ST_D_DIV, ST_DECIDE,
      ST_P_MUL, ST_P_DIV, ST_B_MUL, ST_B_DIV, ST_OUT
   } state_type;

   // configuration registers
   logic [15:0] desired_ff, accel_ff, tmin_ff, cmin_ff, max_step_ff;
   logic [19:0] goal_rad_ff, clr_rad_ff;
   logic [14:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         desired_ff  <= 16'd0;
         accel_ff    <= 16'd1000;
         goal_rad_ff <= 20'd0;
         thr_ff      <= 15'd16384;
         tmin_ff     <= 16'd0;
         clr_rad_ff  <= 20'd0;
         cmin_ff     <= 16'd0;
         max_step_ff <= 16'd0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_DESIRED:     desired_ff  <= csr_wdata[15:0];
            REG_MAX_ACCEL:   accel_ff    <= csr_wdata[15:0];
            REG_GOAL_RADIUS: goal_rad_ff <= csr_wdata;
            REG_TURN_THR:    thr_ff      <= csr_wdata[14:0];
            REG_TURN_MIN:    tmin_ff     <= csr_wdata[15:0];
            REG_CLR_RADIUS:  clr_rad_ff  <= csr_wdata;
            REG_CLR_MIN:     cmin_ff     <= csr_wdata[15:0];
            REG_MAX_STEP:    max_step_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // control and working registers
   state_type   state_ff;
   logic        pend_ff, rsp_valid_ff;
   logic [15:0] prev_ff;
   logic [19:0] dist_ff, clr_ff, dt_ff;
   logic [15:0] ang_ff, meas_ff;
   logic        meas_known_ff, g_ramp_ff, t_need_ff, c_need_ff;
   logic [15:0] gl_ff, tl_ff, cl_ff, sc_ff, allowed_ff, req_ff, step_ff;
   logic [16:0] delta_ff;
   logic [19:0] brake_ff;
   logic [3:0]  reason_ff;

   // result register
   logic [15:0] o_req_ff, o_allowed_ff, o_step_ff, o_gl_ff, o_tl_ff, o_cl_ff, o_sc_ff;
   logic [19:0] o_brake_ff;
   logic [3:0]  o_reason_ff;

   // effective ramp floors
   logic [15:0] tmin_eff, cmin_eff;
   assign tmin_eff = (tmin_ff < desired_ff) ? tmin_ff : desired_ff;
   assign cmin_eff = (cmin_ff < desired_ff) ? cmin_ff : desired_ff;

   // request-side decode of the turn and clearance cases
   logic [16:0] ang_wide;
   logic [15:0] ang_abs, t_direct, c_direct;
   logic        t_need, c_need, g_ramp;

   always_comb begin
      ang_wide = req_turn_angle[15] ? (17'h10000 - {1'b0, req_turn_angle})
                                    : {1'b0, req_turn_angle};
      ang_abs  = ang_wide[15:0];   // most negative angle maps to pi
      t_need   = 1'b0;
      if (desired_ff == 16'd0)
         t_direct = 16'd0;
      else if (ang_abs <= {1'b0, thr_ff})
         t_direct = desired_ff;
      else if ({1'b0, thr_ff} >= HALF_PI || ang_abs >= HALF_PI)
         t_direct = tmin_eff;
      else begin
         t_direct = desired_ff;
         t_need   = 1'b1;
      end
      c_need   = 1'b0;
      c_direct = desired_ff;
      if (req_clearance_known && desired_ff != 16'd0 && clr_rad_ff != 20'd0 &&
          req_clearance < clr_rad_ff)
         c_need = 1'b1;
      g_ramp = (goal_rad_ff != 20'd0) && (req_goal_distance < goal_rad_ff);
   end

   // serial unit
   slg_cmd_type  cmd;
   logic [35:0]  opa, res;
   logic [20:0]  opb;
   logic         unit_done;

   slg_serial u_serial (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .done   (unit_done),
      .result (res)
   );

   logic [19:0] rem_dist;
   assign rem_dist = (dist_ff > MARGIN) ? (dist_ff - MARGIN) : 20'd0;

   always_comb begin
      cmd.op = OP_MUL;
      opa    = 36'd0;
      opb    = 21'd0;
      case (state_ff)
         ST_G_MUL: begin
            opa = {20'd0, accel_ff};
            opb = {1'b0, rem_dist};
         end
         ST_G_SQRT: begin
            cmd.op = OP_SQRT;
            opa    = {res[34:0], 1'b0};
         end
         ST_R_MUL: begin
            opa = {20'd0, desired_ff};
            opb = {1'b0, dist_ff};
         end
         ST_R_DIV: begin
            cmd.op = OP_DIV;
            opa    = res;
            opb    = {1'b0, goal_rad_ff};
         end
         ST_T_MUL: begin
            opa = {20'd0, desired_ff - tmin_eff};
            opb = {5'd0, ang_ff - {1'b0, thr_ff}};
         end
         ST_T_DIV: begin
            cmd.op = OP_DIV;
            opa    = res;
            opb    = {5'd0, HALF_PI - {1'b0, thr_ff}};
         end
         ST_C_MUL: begin
            opa = {20'd0, desired_ff - cmin_eff};
            opb = {1'b0, clr_ff};
         end
         ST_C_DIV: begin
            cmd.op = OP_DIV;
            opa    = res;
            opb    = {1'b0, clr_rad_ff};
         end
         ST_S_MUL: begin
            opa = {20'd0, max_step_ff};
            opb = {1'b0, US_PER_S};
         end
         ST_S_DIV: begin
            cmd.op = OP_DIV;
            opa    = res;
            opb    = {1'b0, dt_ff};
         end
         ST_D_MUL: begin
            opa = {20'd0, accel_ff};
            opb = {1'b0, dt_ff};
         end
         ST_D_DIV, ST_P_DIV: begin
            cmd.op = OP_DIV;
            opa    = res;
            opb    = {1'b0, US_PER_S};
         end
         ST_P_MUL: begin
            opa = {20'd0, req_ff};
            opb = {1'b0, dt_ff};
         end
         ST_B_MUL: begin
            opa = {20'd0, req_ff};
            opb = {5'd0, req_ff};
         end
         ST_B_DIV: begin
            cmd.op = OP_DIV;
            opa    = res;
            opb    = {4'd0, accel_ff, 1'b0};
         end
         default: ;
      endcase
      cmd.start = (state_ff != ST_IDLE) && (state_ff != ST_DECIDE) &&
                  (state_ff != ST_OUT) && !pend_ff;
   end

   // skip chain for the optional ramps
   state_type after_t, after_r, after_g;
   assign after_t = c_need_ff ? ST_C_MUL : ST_S_MUL;
   assign after_r = t_need_ff ? ST_T_MUL : after_t;
   assign after_g = g_ramp_ff ? ST_R_MUL : after_r;

   // limit selection, accel ramp, floor, overspeed and step cap
   logic [15:0] allowed_c, req_c, diff_c, back_c, safe_c, m1, m2;
   logic [3:0]  reason_c;
   logic [17:0] over_lim;

   always_comb begin
      allowed_c = desired_ff;
      reason_c  = RSN_CRUISE;
      if (gl_ff < allowed_c) begin
         allowed_c = gl_ff;
         reason_c  = RSN_GOAL;
      end
      if (tl_ff < allowed_c) begin
         allowed_c = tl_ff;
         reason_c  = RSN_TURN;
      end
      if (cl_ff < allowed_c) begin
         allowed_c = cl_ff;
         reason_c  = RSN_CLEARANCE;
      end

      if (allowed_c >= prev_ff) begin
         diff_c = allowed_c - prev_ff;
         req_c  = ({1'b0, diff_c} <= delta_ff) ? allowed_c : (prev_ff + delta_ff[15:0]);
      end else begin
         diff_c = prev_ff - allowed_c;
         req_c  = ({1'b0, diff_c} <= delta_ff) ? allowed_c : (prev_ff - delta_ff[15:0]);
      end
      if (prev_ff < allowed_c && req_c < allowed_c)
         reason_c = RSN_ACCEL;

      m1     = (MIN_SPD < desired_ff) ? MIN_SPD : desired_ff;
      m2     = (allowed_c < sc_ff) ? allowed_c : sc_ff;
      safe_c = (m1 < m2) ? m1 : m2;
      if (MIN_SPD != 16'd0 && req_c != 16'd0 && allowed_c != 16'd0 && sc_ff != 16'd0 &&
          safe_c > req_c)
         req_c = safe_c;

      if (allowed_c < req_c)
         req_c = allowed_c;

      over_lim = {2'b00, allowed_c} + {1'b0, delta_ff};
      back_c   = ({1'b0, allowed_c} > delta_ff) ? (allowed_c - delta_ff[15:0]) : 16'd0;
      if (meas_known_ff && {2'b00, meas_ff} > over_lim) begin
         if (back_c < req_c)
            req_c = back_c;
         reason_c = RSN_OVERSPEED;
      end

      if (sc_ff < req_c) begin
         req_c    = sc_ff;
         reason_c = RSN_STEPCAP;
      end
   end

   // result register load: the slot is empty or drains this cycle
   logic out_fire;
   assign out_fire = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= 16'd0;
      end else begin
         if (out_fire)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         if (cmd.start)
            pend_ff <= 1'b1;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  dist_ff       <= req_goal_distance;
                  clr_ff        <= req_clearance;
                  dt_ff         <= req_time_step;
                  ang_ff        <= ang_abs;
                  meas_ff       <= req_measured_speed;
                  meas_known_ff <= req_measured_known;
                  g_ramp_ff     <= g_ramp;
                  t_need_ff     <= t_need;
                  c_need_ff     <= c_need;
                  if (req_hold || accel_ff == 16'd0 || req_time_step == 20'd0) begin
                     gl_ff      <= 16'd0;
                     tl_ff      <= 16'd0;
                     cl_ff      <= 16'd0;
                     sc_ff      <= 16'd0;
                     allowed_ff <= 16'd0;
                     req_ff     <= 16'd0;
                     step_ff    <= 16'd0;
                     brake_ff   <= 20'd0;
                     reason_ff  <= req_hold ? RSN_HOLD : RSN_INVALID;
                     state_ff   <= ST_OUT;
                  end else begin
                     tl_ff    <= t_direct;
                     cl_ff    <= c_direct;
                     state_ff <= ST_G_MUL;
                  end
               end
            end
            ST_DECIDE: begin
               allowed_ff <= allowed_c;
               req_ff     <= req_c;
               reason_ff  <= reason_c;
               state_ff   <= ST_P_MUL;
            end
            ST_OUT: begin
               if (out_fire) begin
                  o_req_ff     <= req_ff;
                  o_allowed_ff <= allowed_ff;
                  o_step_ff    <= step_ff;
                  o_brake_ff   <= brake_ff;
                  o_gl_ff      <= gl_ff;
                  o_tl_ff      <= tl_ff;
                  o_cl_ff      <= cl_ff;
                  o_sc_ff      <= sc_ff;
                  o_reason_ff  <= reason_ff;
                  prev_ff      <= req_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               if (pend_ff && unit_done) begin
                  pend_ff <= 1'b0;
                  case (state_ff)
                     ST_G_MUL: begin
                        // root saturates once 2*a*d reaches 2^32
                        if (res[35:31] != 5'd0) begin
                           gl_ff    <= 16'hFFFF;
                           state_ff <= after_g;
                        end else begin
                           state_ff <= ST_G_SQRT;
                        end
                     end
                     ST_G_SQRT: begin
                        gl_ff    <= res[15:0];
                        state_ff <= after_g;
                     end
                     ST_R_MUL: state_ff <= ST_R_DIV;
                     ST_R_DIV: begin
                        if (res[15:0] < gl_ff)
                           gl_ff <= res[15:0];
                        state_ff <= after_r;
                     end
                     ST_T_MUL: state_ff <= ST_T_DIV;
                     ST_T_DIV: begin
                        tl_ff    <= desired_ff - res[15:0];
                        state_ff <= after_t;
                     end
                     ST_C_MUL: state_ff <= ST_C_DIV;
                     ST_C_DIV: begin
                        cl_ff    <= cmin_eff + res[15:0];
                        state_ff <= ST_S_MUL;
                     end
                     ST_S_MUL: state_ff <= ST_S_DIV;
                     ST_S_DIV: begin
                        sc_ff    <= (res[35:16] != 20'd0) ? 16'hFFFF : res[15:0];
                        state_ff <= ST_D_MUL;
                     end
                     ST_D_MUL: state_ff <= ST_D_DIV;
                     ST_D_DIV: begin
                        delta_ff <= res[16:0];
                        state_ff <= ST_DECIDE;
                     end
                     ST_P_MUL: state_ff <= ST_P_DIV;
                     ST_P_DIV: begin
                        step_ff  <= (res[35:16] != 20'd0) ? 16'hFFFF : res[15:0];
                        state_ff <= ST_B_MUL;
                     end
                     ST_B_MUL: state_ff <= ST_B_DIV;
                     ST_B_DIV: begin
                        brake_ff <= (res[35:20] != 16'd0) ? 20'hFFFFF : res[19:0];
                        state_ff <= ST_OUT;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
         endcase
      end
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_requested_speed  = o_req_ff;
   assign rsp_allowed_speed    = o_allowed_ff;
   assign rsp_target_step      = o_step_ff;
   assign rsp_braking_distance = o_brake_ff;
   assign rsp_goal_limit       = o_gl_ff;
   assign rsp_turn_limit       = o_tl_ff;
   assign rsp_clearance_limit  = o_cl_ff;
   assign rsp_step_cap_limit   = o_sc_ff;
   assign rsp_limit_reason     = o_reason_ff;

endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the speed limit governor.
`timescale 1ns / 1ps
`default_nettype none

class speed_scoreboard;
   // mirrored registers and kept speed
   int unsigned desired, accel, goal_rad, turn_thr, turn_min;
   int unsigned clr_rad, clr_min, max_step, kept_speed;
   logic [135:0] pending[$];
   int unsigned  mismatches;

   function void reset_state();
      desired = 0; accel = 1000; goal_rad = 0; turn_thr = 16384; turn_min = 0;
      clr_rad = 0; clr_min = 0; max_step = 0; kept_speed = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [19:0] val);
      case (idx)
         slg_pkg::REG_DESIRED:     desired  = val[15:0];
         slg_pkg::REG_MAX_ACCEL:   accel    = val[15:0];
         slg_pkg::REG_GOAL_RADIUS: goal_rad = val;
         slg_pkg::REG_TURN_THR:    turn_thr = val[14:0];
         slg_pkg::REG_TURN_MIN:    turn_min = val[15:0];
         slg_pkg::REG_CLR_RADIUS:  clr_rad  = val;
         slg_pkg::REG_CLR_MIN:     clr_min  = val[15:0];
         slg_pkg::REG_MAX_STEP:    max_step = val[15:0];
         default: ;
      endcase
   endfunction

   function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function longint unsigned sat16(longint unsigned v);
      return v > 65535 ? 65535 : v;
   endfunction

   function void note_request(logic hold, logic [19:0] goal_mm, logic [15:0] ang_bits,
                              logic [19:0] clr, logic clr_ok, logic [19:0] dt,
                              logic [15:0] meas, logic meas_ok);
      longint unsigned gl, tl, cl, sc, allowed, req, delta, ang, mn, stp, brk;
      logic [3:0] why;
      if (hold) begin
         kept_speed = 0; pending.push_back('0); return;
      end
      if (accel == 0 || dt == 0) begin
         kept_speed = 0;
         pending.push_back({132'd0, slg_pkg::RSN_INVALID}); return;
      end
      gl = sat16(root(2 * longint'(accel) * goal_mm));
      if (goal_rad > 0 && goal_mm < goal_rad && (longint'(desired) * goal_mm) / goal_rad < gl)
         gl = (longint'(desired) * goal_mm) / goal_rad;
      ang = ang_bits[15] ? 65536 - ang_bits : ang_bits;
      if (desired == 0) tl = 0;
      else if (ang <= turn_thr) tl = desired;
      else begin
         mn = turn_min < desired ? turn_min : desired;
         if (turn_thr >= 16384 || ang >= 16384) tl = mn;
         else tl = desired - ((desired - mn) * (ang - turn_thr)) / (16384 - turn_thr);
      end
      if (!clr_ok || desired == 0 || clr_rad == 0 || clr >= clr_rad) cl = desired;
      else begin
         mn = clr_min < desired ? clr_min : desired;
         cl = mn + ((longint'(desired) - mn) * clr) / clr_rad;
      end
      sc = sat16((longint'(max_step) * 1000000) / dt);
      allowed = desired; why = slg_pkg::RSN_CRUISE;
      if (gl < allowed) begin allowed = gl; why = slg_pkg::RSN_GOAL; end
      if (tl < allowed) begin allowed = tl; why = slg_pkg::RSN_TURN; end
      if (cl < allowed) begin allowed = cl; why = slg_pkg::RSN_CLEARANCE; end
      delta = (longint'(accel) * dt) / 1000000;
      if (allowed >= kept_speed)
         req = (allowed - kept_speed <= delta) ? allowed : kept_speed + delta;
      else
         req = (kept_speed - allowed <= delta) ? allowed : kept_speed - delta;
      if (kept_speed < allowed && req < allowed) why = slg_pkg::RSN_ACCEL;
      if (allowed < req) req = allowed;
      if (meas_ok && meas > allowed + delta) begin
         mn = allowed > delta ? allowed - delta : 0;
         if (mn < req) req = mn;
         why = slg_pkg::RSN_OVERSPEED;
      end
      if (sc < req) begin req = sc; why = slg_pkg::RSN_STEPCAP; end
      kept_speed = req[15:0];
      stp = sat16((req * dt) / 1000000);
      brk = (req * req) / (2 * longint'(accel));
      if (brk > 20'hFFFFF) brk = 20'hFFFFF;
      pending.push_back({req[15:0], allowed[15:0], stp[15:0], brk[19:0], gl[15:0],
                         tl[15:0], cl[15:0], sc[15:0], why});
   endfunction

   function void check_result(logic [135:0] got);
      logic [135:0] exp;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
         mismatches++;
         if (mismatches <= 10) $display("result mismatch: expected %h actual %h", exp, got);
      end
   endfunction
endclass

module testbench;
   import slg_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, req_hold = 0, req_clearance_known = 0;
   logic req_measured_known = 0;
   logic [19:0] req_goal_distance = 0, req_clearance = 0, req_time_step = 0;
   logic signed [15:0] req_turn_angle = 0;
   logic [15:0] req_measured_speed = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [15:0] rsp_requested_speed, rsp_allowed_speed, rsp_target_step, rsp_goal_limit;
   logic [15:0] rsp_turn_limit, rsp_clearance_limit, rsp_step_cap_limit;
   logic [19:0] rsp_braking_distance;
   logic [3:0]  rsp_limit_reason;
   logic csr_we = 0;
   logic [2:0] csr_addr = 0;
   logic [19:0] csr_wdata = 0;

   speed_scoreboard sb = new();
   int send_idle_pct = 0, recv_stall_pct = 0;
   bit stall_arm = 0;    // asks for the long hold-off once
   bit stall_used = 0;
   int hold_off = 0;     // cycles the receiver keeps ready low, counted below

   speed_limit_governor u_dut (.*);

   initial forever #10 clock = ~clock;

   // Result side: random stalls plus the long hold-off; checks on every transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_requested_speed, rsp_allowed_speed, rsp_target_step,
                          rsp_braking_distance, rsp_goal_limit, rsp_turn_limit,
                          rsp_clearance_limit, rsp_step_cap_limit, rsp_limit_reason});
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else if (stall_arm && !stall_used) begin
         hold_off <= 3000;
         stall_used <= 1;
         rsp_ready <= 0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_csr(logic [2:0] idx, logic [19:0] val);
      @(posedge clock);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
      csr_we <= 0;
   endtask

   // Offers one tick, holds it until the transfer, then notes it.
   // Valid stays high after the transfer unless the next call idles or drains.
   task automatic send_tick(logic hold, logic [19:0] goal_mm, logic [15:0] ang,
                            logic [19:0] clr, logic clr_ok, logic [19:0] dt,
                            logic [15:0] meas, logic meas_ok);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1; req_hold <= hold; req_goal_distance <= goal_mm;
      req_turn_angle <= ang; req_clearance <= clr; req_clearance_known <= clr_ok;
      req_time_step <= dt; req_measured_speed <= meas; req_measured_known <= meas_ok;
      do @(posedge clock); while (!req_ready);
      sb.note_request(hold, goal_mm, ang, clr, clr_ok, dt, meas, meas_ok);
   endtask

   task automatic random_tick();
      logic [19:0] dt, goal_mm, clr;
      logic [15:0] meas;
      case ($urandom_range(3))
         0: dt = 20'($urandom_range(1000000));
         1: dt = 20'($urandom_range(1, 40000));
         2: dt = 20'($urandom_range(1, 5));
         default: dt = 20'($urandom);
      endcase
      if ($urandom_range(49) == 0) dt = 0;
      goal_mm = $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(5000));
      clr     = $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(5000));
      meas    = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3000));
      send_tick($urandom_range(19) == 0, goal_mm, 16'($urandom), clr, 1'($urandom), dt,
                meas, 1'($urandom));
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(posedge clock); guard++;
      end
      repeat (500) @(posedge clock);
   endtask

   task automatic random_config(bit extreme);
      write_csr(REG_DESIRED,     extreme ? 20'hFFFF : 20'($urandom_range(3000)));
      write_csr(REG_MAX_ACCEL,   extreme ? 20'hFFFF : 20'($urandom_range(1, 65535)));
      write_csr(REG_GOAL_RADIUS, extreme ? 20'hFFFFF : ($urandom_range(1) ? 20'($urandom) : 20'd0));
      write_csr(REG_TURN_THR,    extreme ? 20'h7FFF : 20'($urandom_range(16383)));
      write_csr(REG_TURN_MIN,    extreme ? 20'hFFFF : 20'($urandom_range(1500)));
      write_csr(REG_CLR_RADIUS,  extreme ? 20'hFFFFF : ($urandom_range(1) ? 20'($urandom) : 20'd0));
      write_csr(REG_CLR_MIN,     extreme ? 20'hFFFF : 20'($urandom_range(1500)));
      write_csr(REG_MAX_STEP,    extreme ? 20'hFFFF : 20'($urandom_range(65535)));
   endtask

   initial begin
      int ph;
      sb.reset_state();
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed: defaults first (desired 0), then a mid setting
      send_tick(0, 0, 0, 0, 0, 1000, 0, 0);
      drain();
      write_csr(REG_DESIRED, 2000); write_csr(REG_MAX_ACCEL, 4000);
      write_csr(REG_GOAL_RADIUS, 3000); write_csr(REG_TURN_THR, 4000);
      write_csr(REG_TURN_MIN, 300); write_csr(REG_CLR_RADIUS, 2000);
      write_csr(REG_CLR_MIN, 200); write_csr(REG_MAX_STEP, 100);
      send_tick(1, 500, 0, 0, 0, 1000, 0, 0);               // hold
      send_tick(0, 500, 0, 0, 0, 0, 0, 0);                  // zero period
      send_tick(0, 20'hFFFFF, 0, 0, 0, 10000, 0, 0);        // cruise / accel
      send_tick(0, 20'hFFFFF, 0, 0, 0, 1000000, 0, 0);
      send_tick(0, 1000, 0, 0, 0, 10000, 0, 0);             // goal
      send_tick(0, 20'hFFFFF, 16'sd8000, 0, 0, 10000, 0, 0);   // turn ramp
      send_tick(0, 20'hFFFFF, -16'sd32768, 0, 0, 10000, 0, 0); // most negative
      send_tick(0, 20'hFFFFF, 16'sd32767, 0, 0, 10000, 0, 0);
      send_tick(0, 20'hFFFFF, 0, 500, 1, 10000, 0, 0);      // clearance
      send_tick(0, 20'hFFFFF, 0, 0, 1, 10000, 0, 0);
      send_tick(0, 20'hFFFFF, 0, 20'hFFFFF, 0, 10000, 16'hFFFF, 1); // overspeed
      send_tick(0, 20'hFFFFF, 0, 0, 0, 20'hFFFFF, 0, 1);    // step cap
      send_tick(0, 20'hFFFFF, 0, 0, 0, 1, 0, 0);
      drain();
      write_csr(REG_MAX_ACCEL, 0);                          // unusable accel
      send_tick(0, 100, 0, 0, 0, 1000, 0, 0);
      drain();
      random_config(1);
      send_tick(0, 20'hFFFFF, 0, 0, 0, 1000000, 0, 0);
      send_tick(0, 20'hFFFFF, 0, 0, 0, 1000000, 0, 0);
      drain();
      // random phases with varied idling and settings
      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         random_config(ph == 4);
         if (ph == 2) stall_arm = 1;   // sender keeps offering while results back up
         repeat (85) random_tick();
         drain();
      end
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #200ms;
      $display("testbench: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
